FILE: rtl/fault_code_unique_collector_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the trouble code collector
// Every macro samples on clk_i and is disabled while rst_ni is low.
// ---------------------------------------------------------------------------
`ifndef FAULT_CODE_UNIQUE_COLLECTOR_MACROS_SVH
`define FAULT_CODE_UNIQUE_COLLECTOR_MACROS_SVH

// Plain property that must hold at every clock edge
`define FCUC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication
`define FCUC_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define FCUC_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/fcuc_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fcuc_pkg
// Shared constants, command codes and table request/response types.
// ---------------------------------------------------------------------------
package fcuc_pkg;

  localparam int TableDepth = 16;
  localparam int IdxW       = $clog2(TableDepth);
  localparam int CntW       = IdxW + 1;
  localparam int CodeW      = 16;

  typedef enum logic [1:0] {
    CMD_FRAME = 2'd0,
    CMD_ARM   = 2'd1,
    CMD_STOP  = 2'd2,
    CMD_READ  = 2'd3
  } cmd_e;

  typedef enum logic {
    TOP_SEARCH = 1'b0,
    TOP_READ   = 1'b1
  } tbl_op_e;

  // Request from the control FSM to the table engine
  typedef struct packed {
    logic             start;
    tbl_op_e          op;
    logic [CodeW-1:0] code;
    logic [CntW-1:0]  count;
    logic [IdxW-1:0]  index;
  } tbl_req_t;

  // Completion report from the table engine
  typedef struct packed {
    logic             done;
    logic             added;
    logic             overflow;
    logic [CodeW-1:0] data;
  } tbl_rsp_t;

endpackage

FILE: rtl/fcuc_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fcuc_in_if / fcuc_out_if
// Valid/ready channels for command items and result items.
// ---------------------------------------------------------------------------
interface fcuc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] module_id;
  logic [7:0] code_high;
  logic [7:0] code_low;
  logic       crc_good;
  logic       response_valid;
  logic [3:0] read_index;

  modport source (output valid, command, module_id, code_high, code_low, crc_good,
                  response_valid, read_index, input ready);
  modport sink   (input valid, command, module_id, code_high, code_low, crc_good,
                  response_valid, read_index, output ready);
endinterface

interface fcuc_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  code_count;
  logic [7:0]  extra_count;
  logic [31:0] reply_count;
  logic        collecting;
  logic        added_new;
  logic [7:0]  entry_high;
  logic [7:0]  entry_low;

  modport source (output valid, code_count, extra_count, reply_count, collecting,
                  added_new, entry_high, entry_low, input ready);
  modport sink   (input valid, code_count, extra_count, reply_count, collecting,
                  added_new, entry_high, entry_low, output ready);
endinterface

FILE: rtl/fcuc_table.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fcuc_table
// Code table memory with a sequential search-and-insert engine and a
// single-entry read. One memory read per cycle, read data registered.
// ---------------------------------------------------------------------------
`include "fault_code_unique_collector_macros.svh"

module fcuc_table (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  fcuc_pkg::tbl_req_t req_i,
  output fcuc_pkg::tbl_rsp_t rsp_o
);
  import fcuc_pkg::*;

  typedef enum logic [1:0] {
    T_IDLE,
    T_SCAN,
    T_READ
  } tstate_e;

  tstate_e          state_q, state_d;
  logic [CntW-1:0]  ptr_q, ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [CodeW-1:0] code_q, code_d;
  logic             pend_q, pend_d;

  logic [CodeW-1:0] mem_q [TableDepth];
  logic [CodeW-1:0] rdata_q;
  logic [IdxW-1:0]  raddr;
  logic [IdxW-1:0]  waddr;
  logic             we;
  logic             hit;

  // Compare the entry fetched last cycle against the code under search
  assign hit   = pend_q && (rdata_q == code_q);
  assign waddr = count_q[IdxW-1:0];

  // Sequence search, insert and read
  always_comb begin
    state_d = state_q;
    ptr_d   = ptr_q;
    count_d = count_q;
    code_d  = code_q;
    pend_d  = 1'b0;
    raddr   = ptr_q[IdxW-1:0];
    we      = 1'b0;
    rsp_o   = '0;
    unique case (state_q)
      T_IDLE: begin
        if (req_i.start) begin
          count_d = req_i.count;
          code_d  = req_i.code;
          ptr_d   = '0;
          if (req_i.op == TOP_READ) begin
            raddr   = req_i.index;
            state_d = T_READ;
          end else begin
            state_d = T_SCAN;
          end
        end
      end
      T_SCAN: begin
        if (hit) begin
          // duplicate: nothing to store
          rsp_o.done = 1'b1;
          state_d    = T_IDLE;
        end else if (ptr_q == count_q) begin
          // every stored entry checked: append or flag overflow
          rsp_o.done = 1'b1;
          if (count_q < CntW'(TableDepth)) begin
            we          = 1'b1;
            rsp_o.added = 1'b1;
          end else begin
            rsp_o.overflow = 1'b1;
          end
          state_d = T_IDLE;
        end else begin
          raddr  = ptr_q[IdxW-1:0];
          ptr_d  = ptr_q + CntW'(1);
          pend_d = 1'b1;
        end
      end
      T_READ: begin
        rsp_o.done = 1'b1;
        rsp_o.data = rdata_q;
        state_d    = T_IDLE;
      end
      default: state_d = T_IDLE;
    endcase
  end

  // Hold engine control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= T_IDLE;
      ptr_q   <= '0;
      count_q <= '0;
      code_q  <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      ptr_q   <= ptr_d;
      count_q <= count_d;
      code_q  <= code_d;
      pend_q  <= pend_d;
    end
  end

  // Code memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= code_q;
    end
    rdata_q <= mem_q[raddr];
  end

  `FCUC_IMPLY(a_ptr_in_range, state_q == T_SCAN, ptr_q <= count_q, "scan pointer overran count")
  `FCUC_IMPLY(a_write_room, we, count_q < CntW'(TableDepth), "insert into a full table")
  `FCUC_NEXT(a_done_idle, rsp_o.done, state_q == T_IDLE, "engine did not return to idle")

endmodule

FILE: rtl/fault_code_unique_collector.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fault_code_unique_collector
// Collects distinct trouble codes reported by one target module. Takes one
// command item at a time and returns one result item per command.
// ---------------------------------------------------------------------------
// Timing: arm, stop, frames that are ignored or carry a zero code, and reads
// of empty slots skip the table and go straight to the result register. A
// read of a stored slot passes through the table's registered read port. A
// counted frame with a nonzero code searches the code table one entry per
// cycle through its single read port, checking up to N entries with N codes
// stored (16 with a full table); a duplicate ends the search at the matching
// entry. The table needs no clearing after reset or arm: the stored count
// bounds every access. A finished result sits in an output register and a
// new item may be taken while it waits.
// ---------------------------------------------------------------------------
`include "fault_code_unique_collector_macros.svh"

module fault_code_unique_collector (
  input  logic     clk_i,
  input  logic     rst_ni,
  fcuc_in_if.sink  in_i,
  fcuc_out_if.source out_o
);
  import fcuc_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WAIT,
    S_EMIT
  } state_e;

  state_e           state_q, state_d;
  logic             armed_q, armed_d;
  logic [7:0]       target_q, target_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [7:0]       extra_q, extra_d;
  logic [31:0]      reply_q, reply_d;
  logic             added_q, added_d;
  logic [CodeW-1:0] entry_q, entry_d;

  logic             out_valid_q, out_valid_d;
  logic [4:0]       o_count_q, o_count_d;
  logic [7:0]       o_extra_q, o_extra_d;
  logic [31:0]      o_reply_q, o_reply_d;
  logic             o_coll_q, o_coll_d;
  logic             o_added_q, o_added_d;
  logic [CodeW-1:0] o_entry_q, o_entry_d;

  cmd_e             cmd;
  logic             accept;
  logic             frame_ok;
  logic [CodeW-1:0] code;
  tbl_req_t         tbl_req;
  tbl_rsp_t         tbl_rsp;
  logic             tbl_add;
  logic             tbl_ovf;

  assign cmd      = cmd_e'(in_i.command);
  assign accept   = in_i.valid && in_i.ready;
  assign code     = {in_i.code_high, in_i.code_low};
  assign frame_ok = in_i.crc_good && in_i.response_valid && armed_q
                    && (in_i.module_id == target_q);
  assign in_i.ready = (state_q == S_IDLE);

  // Decode commands, track the table engine, load the result register
  always_comb begin
    state_d     = state_q;
    armed_d     = armed_q;
    target_d    = target_q;
    count_d     = count_q;
    extra_d     = extra_q;
    reply_d     = reply_q;
    added_d     = added_q;
    entry_d     = entry_q;
    out_valid_d = out_valid_q && !out_o.ready;
    o_count_d   = o_count_q;
    o_extra_d   = o_extra_q;
    o_reply_d   = o_reply_q;
    o_coll_d    = o_coll_q;
    o_added_d   = o_added_q;
    o_entry_d   = o_entry_q;
    tbl_req       = '0;
    tbl_req.op    = TOP_SEARCH;
    tbl_req.code  = code;
    tbl_req.count = count_q;
    tbl_req.index = in_i.read_index[IdxW-1:0];

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          added_d = 1'b0;
          entry_d = '0;
          state_d = S_EMIT;
          unique case (cmd)
            CMD_FRAME: begin
              if (frame_ok) begin
                reply_d = reply_q + 32'd1;
                if (code != '0) begin
                  tbl_req.start = 1'b1;
                  state_d       = S_WAIT;
                end
              end
            end
            CMD_ARM: begin
              target_d = in_i.module_id;
              count_d  = '0;
              extra_d  = '0;
              reply_d  = '0;
              armed_d  = 1'b1;
            end
            CMD_STOP: begin
              armed_d = 1'b0;
            end
            CMD_READ: begin
              if (CntW'(in_i.read_index) < count_q) begin
                tbl_req.start = 1'b1;
                tbl_req.op    = TOP_READ;
                state_d       = S_WAIT;
              end
            end
            default: state_d = S_EMIT;
          endcase
        end
      end
      S_WAIT: begin
        if (tbl_rsp.done) begin
          if (tbl_rsp.added) begin
            count_d = count_q + CntW'(1);
          end
          if (tbl_rsp.overflow && (extra_q != 8'hFF)) begin
            extra_d = extra_q + 8'd1;
          end
          added_d = tbl_rsp.added;
          entry_d = tbl_rsp.data;
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        // hold until the result register is free
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          o_count_d   = 5'(count_q);
          o_extra_d   = extra_q;
          o_reply_d   = reply_q;
          o_coll_d    = armed_q;
          o_added_d   = added_q;
          o_entry_d   = entry_q;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Hold state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      armed_q     <= 1'b0;
      target_q    <= '0;
      count_q     <= '0;
      extra_q     <= '0;
      reply_q     <= '0;
      added_q     <= 1'b0;
      entry_q     <= '0;
      out_valid_q <= 1'b0;
      o_count_q   <= '0;
      o_extra_q   <= '0;
      o_reply_q   <= '0;
      o_coll_q    <= 1'b0;
      o_added_q   <= 1'b0;
      o_entry_q   <= '0;
    end else begin
      state_q     <= state_d;
      armed_q     <= armed_d;
      target_q    <= target_d;
      count_q     <= count_d;
      extra_q     <= extra_d;
      reply_q     <= reply_d;
      added_q     <= added_d;
      entry_q     <= entry_d;
      out_valid_q <= out_valid_d;
      o_count_q   <= o_count_d;
      o_extra_q   <= o_extra_d;
      o_reply_q   <= o_reply_d;
      o_coll_q    <= o_coll_d;
      o_added_q   <= o_added_d;
      o_entry_q   <= o_entry_d;
    end
  end

  // Table memory and search engine
  fcuc_table u_table (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (tbl_req),
    .rsp_o  (tbl_rsp)
  );

  // Drive the result channel
  assign out_o.valid       = out_valid_q;
  assign out_o.code_count  = o_count_q;
  assign out_o.extra_count = o_extra_q;
  assign out_o.reply_count = o_reply_q;
  assign out_o.collecting  = o_coll_q;
  assign out_o.added_new   = o_added_q;
  assign out_o.entry_high  = o_entry_q[CodeW-1:8];
  assign out_o.entry_low   = o_entry_q[7:0];

  // Flag engine completions that insert or overflow
  assign tbl_add = tbl_rsp.done && tbl_rsp.added;
  assign tbl_ovf = tbl_rsp.done && tbl_rsp.overflow;

  `FCUC_ASSERT(a_count_max, count_q <= CntW'(TableDepth), "stored count above table depth")
  `FCUC_IMPLY(a_done_in_wait, tbl_rsp.done, state_q == S_WAIT, "table done outside wait")
  `FCUC_NEXT(a_add_incr, tbl_add, count_q == $past(count_q) + CntW'(1), "count not bumped")
  `FCUC_IMPLY(a_ovf_full, tbl_ovf, count_q == CntW'(TableDepth), "overflow with room left")

endmodule
